// File: rtl/core/vfm_pkg.sv
// shared types and constants for the value frequency mode finder
// no dependencies

package vfm_pkg;

	localparam int DISTINCT_MAX = 16;
	localparam int RECORDS_MAX  = 4096;

	localparam int KEY_W   = 31;
	localparam int FREQ_W  = 13;
	localparam int IDX_W   = $clog2(DISTINCT_MAX);
	localparam int USED_W  = $clog2(DISTINCT_MAX + 1);
	localparam int ENTRY_W = KEY_W + FREQ_W;

	localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(RECORDS_MAX);
	localparam logic [USED_W-1:0] USED_MAX = USED_W'(DISTINCT_MAX);

	typedef enum logic [1:0] {
		KIND_DISTINCT = 2'd0,
		KIND_MAX      = 2'd1,
		KIND_MIN      = 2'd2
	} kind_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             last;
	} req_t;

	typedef struct packed {
		kind_t             kind;
		logic [KEY_W-1:0]  value;
		logic [FREQ_W-1:0] frequency;
		logic              table_full;
		logic              end_of_run;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]  value;
		logic [FREQ_W-1:0] count;
	} entry_t;

endpackage

// File: rtl/core/vfm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module vfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/value_frequency_mode_finder_core.sv
// an item searches the stored entries in order, one entry-memory read per cycle
// a last item adds a scan for the maximum and minimum counts, then reads and checks each entry
// in each of three result runs (distinct, maximum, minimum), held by any output stall
// input stalls while an item or its results are in work; one output register
// reset clears the entry count, overflow flag and control; the entry memory is not cleared
// depends on vfm_pkg and vfm_ram

module value_frequency_mode_finder_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  vfm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output vfm_pkg::rsp_t rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SCAN,
		ST_EMIT_RD,
		ST_EMIT_CHK
	} state_t;

	state_t                          state_q;
	logic [vfm_pkg::KEY_W-1:0]       key_q;
	logic                            last_q;
	logic [vfm_pkg::USED_W-1:0]      used_q;
	logic                            overflow_q;
	logic [vfm_pkg::USED_W-1:0]      rd_idx_q;
	logic                            d_vld_s1;
	logic [vfm_pkg::IDX_W-1:0]       d_idx_s1;
	logic [vfm_pkg::FREQ_W-1:0]      maxc_q;
	logic [vfm_pkg::FREQ_W-1:0]      minc_q;
	logic [vfm_pkg::IDX_W-1:0]       last_min_idx_q;
	vfm_pkg::kind_t                  pass_q;
	logic [vfm_pkg::IDX_W-1:0]       emit_idx_q;
	logic                            rsp_valid_q;
	vfm_pkg::rsp_t                   rsp_q;

	logic                            ram_we;
	logic [vfm_pkg::IDX_W-1:0]       ram_waddr;
	vfm_pkg::entry_t                 ram_wdata;
	logic                            ram_re;
	logic [vfm_pkg::IDX_W-1:0]       ram_raddr;
	vfm_pkg::entry_t                 ram_rdata;

	logic                            scan_rd;
	logic                            hit;
	logic                            miss;
	logic                            scan_done;
	logic                            qual;
	logic                            out_free;
	logic                            rsp_load;
	logic                            last_entry;
	logic [vfm_pkg::FREQ_W-1:0]      inc_count;

	vfm_ram #(
		.WIDTH (vfm_pkg::ENTRY_W),
		.DEPTH (vfm_pkg::DISTINCT_MAX)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign scan_rd   = (state_q == ST_SEARCH || state_q == ST_SCAN) && (rd_idx_q < used_q);
	assign hit       = (state_q == ST_SEARCH) && d_vld_s1 && (ram_rdata.value == key_q);
	assign miss      = (state_q == ST_SEARCH) && !d_vld_s1 && (rd_idx_q == used_q);
	assign scan_done = !d_vld_s1 && (rd_idx_q == used_q);
	assign inc_count = (ram_rdata.count < vfm_pkg::FREQ_MAX) ?
		ram_rdata.count + vfm_pkg::FREQ_W'(1) : ram_rdata.count;

	assign qual = (pass_q == vfm_pkg::KIND_DISTINCT) ||
		(pass_q == vfm_pkg::KIND_MAX && ram_rdata.count == maxc_q) ||
		(pass_q == vfm_pkg::KIND_MIN && ram_rdata.count == minc_q);
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign rsp_load   = (state_q == ST_EMIT_CHK) && qual && out_free;
	assign last_entry = ({1'b0, emit_idx_q} + vfm_pkg::USED_W'(1)) == used_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = d_idx_s1;
		ram_wdata = '{value: key_q, count: inc_count};
		if (hit) begin
			ram_we = 1'b1;
		end else if (miss && used_q < vfm_pkg::USED_MAX) begin
			ram_we    = 1'b1;
			ram_waddr = used_q[vfm_pkg::IDX_W-1:0];
			ram_wdata = '{value: key_q, count: vfm_pkg::FREQ_W'(1)};
		end
	end

	always_comb begin
		ram_re    = scan_rd;
		ram_raddr = rd_idx_q[vfm_pkg::IDX_W-1:0];
		if (state_q == ST_EMIT_RD) begin
			ram_re    = 1'b1;
			ram_raddr = emit_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			used_q         <= '0;
			overflow_q     <= 1'b0;
			rd_idx_q       <= '0;
			d_vld_s1       <= 1'b0;
			rsp_valid_q    <= 1'b0;
			last_q         <= 1'b0;
			pass_q         <= vfm_pkg::KIND_DISTINCT;
			emit_idx_q     <= '0;
		end else begin
			d_vld_s1 <= scan_rd && !hit && !miss;
			d_idx_s1 <= rd_idx_q[vfm_pkg::IDX_W-1:0];
			if (state_q == ST_IDLE || hit || miss) begin
				rd_idx_q <= '0;
			end else if (scan_rd) begin
				rd_idx_q <= rd_idx_q + vfm_pkg::USED_W'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						key_q   <= req.key;
						last_q  <= req.last;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (hit || miss) begin
						if (miss) begin
							if (used_q < vfm_pkg::USED_MAX) begin
								used_q <= used_q + vfm_pkg::USED_W'(1);
							end else begin
								overflow_q <= 1'b1;
							end
						end
						maxc_q   <= '0;
						minc_q   <= '1;
						state_q  <= last_q ? ST_SCAN : ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (d_vld_s1) begin
						if (ram_rdata.count > maxc_q) begin
							maxc_q <= ram_rdata.count;
						end
						if (ram_rdata.count <= minc_q) begin
							minc_q         <= ram_rdata.count;
							last_min_idx_q <= d_idx_s1;
						end
					end
					if (scan_done) begin
						pass_q     <= vfm_pkg::KIND_DISTINCT;
						emit_idx_q <= '0;
						state_q    <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_CHK;
				end
				ST_EMIT_CHK: begin
					if (!qual || out_free) begin
						if (qual) begin
							rsp_q <= '{
								kind:       pass_q,
								value:      ram_rdata.value,
								frequency:  ram_rdata.count,
								table_full: overflow_q,
								end_of_run: (pass_q == vfm_pkg::KIND_MIN) &&
									(emit_idx_q == last_min_idx_q)
							};
						end
						if (!last_entry) begin
							emit_idx_q <= emit_idx_q + vfm_pkg::IDX_W'(1);
							state_q    <= ST_EMIT_RD;
						end else begin
							emit_idx_q <= '0;
							unique case (pass_q)
								vfm_pkg::KIND_DISTINCT: begin
									pass_q  <= vfm_pkg::KIND_MAX;
									state_q <= ST_EMIT_RD;
								end
								vfm_pkg::KIND_MAX: begin
									pass_q  <= vfm_pkg::KIND_MIN;
									state_q <= ST_EMIT_RD;
								end
								default: begin
									used_q     <= '0;
									overflow_q <= 1'b0;
									state_q    <= ST_IDLE;
								end
							endcase
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_eor_on_min: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.end_of_run) |-> (rsp_q.kind == vfm_pkg::KIND_MIN))
		else $error("end_of_run on a line that is not a minimum frequency line");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= vfm_pkg::USED_MAX)
		else $error("entry count beyond table depth");

	a_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_SEARCH))
		else $error("entry memory written outside of a search");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD && $past(state_q) == ST_SCAN) |-> (minc_q <= maxc_q))
		else $error("scan left minimum count above maximum count");

endmodule
